/* hw/rtl/dmbms_pkg.sv */
// shared types and constants of the display mode best-match selector
`default_nettype none

package dmbms_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

    localparam logic [15:0] END_MARK = 16'hFFFF;
    localparam logic [15:0] NEED_ATTR = 16'h009B;
    localparam logic [7:0] MM_PACKED = 8'd4;
    localparam logic [7:0] MM_DIRECT = 8'd6;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [2:0] REG_PREFER_ENABLE = 3'd0;
    localparam logic [2:0] REG_PREF_WIDTH = 3'd1;
    localparam logic [2:0] REG_PREF_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PREF_DEPTH = 3'd3;
    localparam logic [2:0] REG_PREF_LINE_BYTES = 3'd4;

    typedef struct packed {
        logic        prefer_enable;
        logic [15:0] pref_width;
        logic [15:0] pref_height;
        logic [7:0]  pref_depth;
        logic [15:0] pref_line_bytes;
    } cfg_t;

    typedef struct packed {
        logic [15:0] mode_number;
        logic        query_failed;
        logic [15:0] mode_width;
        logic [15:0] mode_height;
        logic [7:0]  pixel_bits;
        logic [15:0] scan_line_bytes;
        logic [31:0] frame_base;
        logic [7:0]  mem_layout;
        logic [15:0] attributes;
    } mode_t;

    typedef struct packed {
        logic        have_best;
        logic        saw_error;
        logic [2:0]  best_score;
        logic [15:0] best_width;
        logic [15:0] best_height;
        logic [7:0]  best_depth;
    } search_t;

    typedef struct packed {
        logic       is_term;
        logic       set_error;
        logic       take;
        logic [2:0] score;
    } eval_t;

endpackage

`default_nettype wire

/* hw/rtl/display_mode_best_match_selector.sv */
// top level of the display mode best-match selector
// a terminator passes from the input register to the result register, where its result is presented;
// it leaves the input register only once the result register is free
// throughput: one transaction per cycle unless a terminator is held, with combinational evaluation
// mode transactions keep flowing while a result waits; only a terminator waits for m_tready
// reset: synchronous active-low aresetn clears the configuration registers, search state and both valid flags
`default_nettype none

module display_mode_best_match_selector (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dmbms_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [dmbms_pkg::DATA_W-1:0]    pwdata,
    output logic      [dmbms_pkg::DATA_W-1:0]    prdata,
    output logic                                 pready,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // mode_number, mode_width, mode_height, pixel_bits, scan_line_bytes,
    // frame_base, mem_layout, attributes
    input  wire logic [dmbms_pkg::S_TDATA_W-1:0] s_tdata,
    // query_failed
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // chosen_mode, chosen_width, chosen_height, chosen_depth, chosen_line_bytes,
    // chosen_base, match_score, zero pad
    output logic      [dmbms_pkg::M_TDATA_W-1:0] m_tdata,
    // found, error
    output logic      [dmbms_pkg::M_TUSER_W-1:0] m_tuser
);

    dmbms_pkg::cfg_t    cfg;
    dmbms_pkg::mode_t   mode_reg;
    dmbms_pkg::search_t search;
    dmbms_pkg::eval_t   ev;

    logic        in_valid_reg;
    logic        advance;
    logic        have_best_reg;
    logic        saw_error_reg;
    logic [2:0]  best_score_reg;
    logic [15:0] best_mode_reg;
    logic [15:0] best_width_reg;
    logic [15:0] best_height_reg;
    logic [7:0]  best_depth_reg;
    logic [15:0] best_line_bytes_reg;
    logic [31:0] best_base_reg;
    logic        out_valid_reg;
    logic [dmbms_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [dmbms_pkg::M_TUSER_W-1:0] out_user_reg;
    logic [dmbms_pkg::M_TDATA_W-1:0] out_data_next;
    logic [dmbms_pkg::M_TUSER_W-1:0] out_user_next;
    logic        out_free;

    dmbms_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign search.have_best   = have_best_reg;
    assign search.saw_error   = saw_error_reg;
    assign search.best_score  = best_score_reg;
    assign search.best_width  = best_width_reg;
    assign search.best_height = best_height_reg;
    assign search.best_depth  = best_depth_reg;

    dmbms_eval u_eval (
        .mode   (mode_reg),
        .cfg    (cfg),
        .search (search),
        .result (ev)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!ev.is_term || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        out_data_next = '0;
        out_user_next = '0;
        if (saw_error_reg) begin
            out_user_next = 2'b10;
        end else if (have_best_reg) begin
            out_user_next = 2'b01;
            out_data_next = {5'd0, best_score_reg, best_base_reg, best_line_bytes_reg,
                             best_depth_reg, best_height_reg, best_width_reg, best_mode_reg};
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg.mode_number     <= s_tdata[15:0];
            mode_reg.query_failed    <= s_tuser;
            mode_reg.mode_width      <= s_tdata[31:16];
            mode_reg.mode_height     <= s_tdata[47:32];
            mode_reg.pixel_bits      <= s_tdata[55:48];
            mode_reg.scan_line_bytes <= s_tdata[71:56];
            mode_reg.frame_base      <= s_tdata[103:72];
            mode_reg.mem_layout      <= s_tdata[111:104];
            mode_reg.attributes      <= s_tdata[127:112];
        end
    end

    // search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg       <= 1'b0;
            saw_error_reg       <= 1'b0;
            best_score_reg      <= '0;
            best_mode_reg       <= '0;
            best_width_reg      <= '0;
            best_height_reg     <= '0;
            best_depth_reg      <= '0;
            best_line_bytes_reg <= '0;
            best_base_reg       <= '0;
        end else if (advance) begin
            if (ev.is_term) begin
                have_best_reg       <= 1'b0;
                saw_error_reg       <= 1'b0;
                best_score_reg      <= '0;
                best_mode_reg       <= '0;
                best_width_reg      <= '0;
                best_height_reg     <= '0;
                best_depth_reg      <= '0;
                best_line_bytes_reg <= '0;
                best_base_reg       <= '0;
            end else if (ev.set_error) begin
                saw_error_reg <= 1'b1;
            end else if (ev.take) begin
                have_best_reg       <= 1'b1;
                best_score_reg      <= ev.score;
                best_mode_reg       <= mode_reg.mode_number;
                best_width_reg      <= mode_reg.mode_width;
                best_height_reg     <= mode_reg.mode_height;
                best_depth_reg      <= mode_reg.pixel_bits;
                best_line_bytes_reg <= mode_reg.scan_line_bytes;
                best_base_reg       <= mode_reg.frame_base;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && ev.is_term) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ev.is_term) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dmbms_regs.sv */
// apb configuration registers of the display mode best-match selector
`default_nettype none

module dmbms_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dmbms_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dmbms_pkg::DATA_W-1:0] pwdata,
    output logic      [dmbms_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output dmbms_pkg::cfg_t                   cfg
);

    dmbms_pkg::cfg_t cfg_reg;
    dmbms_pkg::cfg_t cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[dmbms_pkg::ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_index)
                dmbms_pkg::REG_PREFER_ENABLE:   cfg_next.prefer_enable = pwdata[0];
                dmbms_pkg::REG_PREF_WIDTH:      cfg_next.pref_width = pwdata[15:0];
                dmbms_pkg::REG_PREF_HEIGHT:     cfg_next.pref_height = pwdata[15:0];
                dmbms_pkg::REG_PREF_DEPTH:      cfg_next.pref_depth = pwdata[7:0];
                dmbms_pkg::REG_PREF_LINE_BYTES: cfg_next.pref_line_bytes = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            dmbms_pkg::REG_PREFER_ENABLE:   prdata = {31'd0, cfg_reg.prefer_enable};
            dmbms_pkg::REG_PREF_WIDTH:      prdata = {16'd0, cfg_reg.pref_width};
            dmbms_pkg::REG_PREF_HEIGHT:     prdata = {16'd0, cfg_reg.pref_height};
            dmbms_pkg::REG_PREF_DEPTH:      prdata = {24'd0, cfg_reg.pref_depth};
            dmbms_pkg::REG_PREF_LINE_BYTES: prdata = {16'd0, cfg_reg.pref_line_bytes};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dmbms_eval.sv */
// mode qualification, mismatch score and replace decision
`default_nettype none

module dmbms_eval (
    input  wire dmbms_pkg::mode_t   mode,
    input  wire dmbms_pkg::cfg_t    cfg,
    input  wire dmbms_pkg::search_t search,
    output dmbms_pkg::eval_t        result
);

    logic       model_ok;
    logic       base_ok;
    logic       attr_ok;
    logic       depth_ok;
    logic       qualifies;
    logic [2:0] score;
    logic       larger;
    logic       better;

    assign model_ok = (mode.mem_layout == dmbms_pkg::MM_PACKED) ||
                      (mode.mem_layout == dmbms_pkg::MM_DIRECT);
    assign base_ok  = (mode.frame_base != 32'd0);
    assign attr_ok  = ((mode.attributes & dmbms_pkg::NEED_ATTR) == dmbms_pkg::NEED_ATTR);
    assign depth_ok = (mode.pixel_bits == dmbms_pkg::DEPTH_16) ||
                      (mode.pixel_bits == dmbms_pkg::DEPTH_24) ||
                      (mode.pixel_bits == dmbms_pkg::DEPTH_32);
    assign qualifies = model_ok && base_ok && attr_ok && depth_ok;

    assign score = {2'b00, cfg.pref_width != mode.mode_width}
                 + {2'b00, cfg.pref_width > mode.mode_width}
                 + {2'b00, cfg.pref_height != mode.mode_height}
                 + {2'b00, cfg.pref_height > mode.mode_height}
                 + {2'b00, cfg.pref_depth != mode.pixel_bits}
                 + {2'b00, cfg.pref_depth > mode.pixel_bits}
                 + {2'b00, cfg.pref_line_bytes != mode.scan_line_bytes};

    assign larger = (search.best_width <= mode.mode_width) &&
                    (search.best_height <= mode.mode_height) &&
                    (search.best_depth <= mode.pixel_bits);
    assign better = cfg.prefer_enable ? (score < search.best_score) : larger;

    always_comb begin
        result.is_term   = (mode.mode_number == dmbms_pkg::END_MARK);
        result.set_error = !result.is_term && !search.saw_error && mode.query_failed;
        result.take      = !result.is_term && !search.saw_error && !mode.query_failed &&
                           qualifies && (!search.have_best || better);
        result.score     = cfg.prefer_enable ? score : 3'd0;
    end

endmodule

`default_nettype wire

/* tb/dmbms_checker.sv */
// checker for the mode selector: tracks register writes and modes, predicts and compares
`timescale 1ns / 1ps

module dmbms_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dmbms_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [dmbms_pkg::DATA_W-1:0]    pwdata,
    input  wire logic                            pready,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // mode_number, mode_width, mode_height, pixel_bits, scan_line_bytes,
    // frame_base, mem_layout, attributes
    input  wire logic [dmbms_pkg::S_TDATA_W-1:0] s_tdata,
    // query_failed
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // chosen_mode, chosen_width, chosen_height, chosen_depth, chosen_line_bytes,
    // chosen_base, match_score, zero pad
    input  wire logic [dmbms_pkg::M_TDATA_W-1:0] m_tdata,
    // found, error
    input  wire logic [dmbms_pkg::M_TUSER_W-1:0] m_tuser,
    output int                                   mismatch_count,
    output int                                   selections_due,
    output int                                   found_count,
    output int                                   empty_count,
    output int                                   aborted_count
);
    import dmbms_pkg::*;

    typedef struct packed {
        logic        found;
        logic        error;
        logic [15:0] mode;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
        logic [15:0] line_bytes;
        logic [31:0] base;
        logic [2:0]  score;
    } selection_t;

    cfg_t       prefs;
    logic       keep_valid;
    logic       aborted;
    selection_t kept;
    selection_t selection_q[$];
    int         errors = 0;
    int         n_found = 0;
    int         n_empty = 0;
    int         n_aborted = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic void clear_search();
        keep_valid = 1'b0;
        aborted    = 1'b0;
        kept       = '0;
    endfunction

    function automatic logic [2:0] mismatch_score(input mode_t m);
        logic [2:0] s;
        s = 3'd0;
        if (m.mode_width != prefs.pref_width) s++;
        if (m.mode_width < prefs.pref_width) s++;
        if (m.mode_height != prefs.pref_height) s++;
        if (m.mode_height < prefs.pref_height) s++;
        if (m.pixel_bits != prefs.pref_depth) s++;
        if (m.pixel_bits < prefs.pref_depth) s++;
        if (m.scan_line_bytes != prefs.pref_line_bytes) s++;
        return s;
    endfunction

    function automatic logic qualifies(input mode_t m);
        return (m.mem_layout == MM_PACKED || m.mem_layout == MM_DIRECT)
            && m.frame_base != '0
            && (m.attributes & NEED_ATTR) == NEED_ATTR
            && (m.pixel_bits == DEPTH_16 || m.pixel_bits == DEPTH_24 || m.pixel_bits == DEPTH_32);
    endfunction

    task automatic take_mode(input mode_t m);
        selection_t res;
        logic [2:0] s;
        logic       grab;
        if (m.mode_number == END_MARK) begin
            res = '0;
            if (aborted) begin
                res.error = 1'b1;
            end else if (keep_valid) begin
                res       = kept;
                res.found = 1'b1;
            end
            selection_q.push_back(res);
            clear_search();
        end else if (!aborted) begin
            if (m.query_failed) begin
                aborted = 1'b1;
            end else if (qualifies(m)) begin
                if (prefs.prefer_enable) begin
                    s    = mismatch_score(m);
                    grab = !keep_valid || s < kept.score;
                end else begin
                    s    = 3'd0;
                    grab = !keep_valid || (kept.width <= m.mode_width
                        && kept.height <= m.mode_height && kept.depth <= m.pixel_bits);
                end
                if (grab) begin
                    keep_valid      = 1'b1;
                    kept.mode       = m.mode_number;
                    kept.width      = m.mode_width;
                    kept.height     = m.mode_height;
                    kept.depth      = m.pixel_bits;
                    kept.line_bytes = m.scan_line_bytes;
                    kept.base       = m.frame_base;
                    kept.score      = s;
                end
            end
        end
    endtask

    task automatic check_selection();
        selection_t got;
        selection_t want;
        got.found      = m_tuser[0];
        got.error      = m_tuser[1];
        got.mode       = m_tdata[15:0];
        got.width      = m_tdata[31:16];
        got.height     = m_tdata[47:32];
        got.depth      = m_tdata[55:48];
        got.line_bytes = m_tdata[71:56];
        got.base       = m_tdata[103:72];
        got.score      = m_tdata[106:104];
        if (selection_q.size() == 0) begin
            report("result with no terminator outstanding, chosen_mode", 32'(got.mode), 32'd0);
            return;
        end
        want = selection_q.pop_front();
        if (got.found != want.found) report("found", 32'(got.found), 32'(want.found));
        if (got.error != want.error) report("error", 32'(got.error), 32'(want.error));
        if (got.mode != want.mode) report("chosen_mode", 32'(got.mode), 32'(want.mode));
        if (got.width != want.width) report("chosen_width", 32'(got.width), 32'(want.width));
        if (got.height != want.height) report("chosen_height", 32'(got.height), 32'(want.height));
        if (got.depth != want.depth) report("chosen_depth", 32'(got.depth), 32'(want.depth));
        if (got.line_bytes != want.line_bytes)
            report("chosen_line_bytes", 32'(got.line_bytes), 32'(want.line_bytes));
        if (got.base != want.base) report("chosen_base", got.base, want.base);
        if (got.score != want.score) report("match_score", 32'(got.score), 32'(want.score));
        if (want.error) n_aborted++;
        else if (want.found) n_found++;
        else n_empty++;
    endtask

    always @(posedge aclk) begin : track
        mode_t item;
        if (!aresetn) begin
            prefs = '0;
            clear_search();
            selection_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_selection();
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_PREFER_ENABLE:   prefs.prefer_enable = pwdata[0];
                    REG_PREF_WIDTH:      prefs.pref_width = pwdata[15:0];
                    REG_PREF_HEIGHT:     prefs.pref_height = pwdata[15:0];
                    REG_PREF_DEPTH:      prefs.pref_depth = pwdata[7:0];
                    REG_PREF_LINE_BYTES: prefs.pref_line_bytes = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                item.mode_number     = s_tdata[15:0];
                item.query_failed    = s_tuser;
                item.mode_width      = s_tdata[31:16];
                item.mode_height     = s_tdata[47:32];
                item.pixel_bits      = s_tdata[55:48];
                item.scan_line_bytes = s_tdata[71:56];
                item.frame_base      = s_tdata[103:72];
                item.mem_layout      = s_tdata[111:104];
                item.attributes      = s_tdata[127:112];
                take_mode(item);
            end
        end
        mismatch_count <= errors;
        selections_due <= selection_q.size();
        found_count    <= n_found;
        empty_count    <= n_empty;
        aborted_count  <= n_aborted;
    end

endmodule

/* tb/tb_display_mode_best_match_selector.sv */
// testbench top: clock, reset, preference programming and mode-list stimulus for the selector
`timescale 1ns / 1ps

module tb_display_mode_best_match_selector;
    import dmbms_pkg::*;

    localparam int          ITEM_GOAL  = 1400;
    localparam int          CALM_AFTER = 1200;
    localparam logic [7:0]  MM_PLANAR  = 8'd3;
    localparam logic [15:0] WIDTHS [5]  = '{16'd640, 16'd800, 16'd1024, 16'd1280, 16'd1920};
    localparam logic [15:0] HEIGHTS [5] = '{16'd480, 16'd600, 16'd768, 16'd1024, 16'd1080};
    localparam logic [7:0]  DEPTHS [3]  = '{DEPTH_16, DEPTH_24, DEPTH_32};
    localparam int          NEED_BITS [5] = '{0, 1, 3, 4, 7};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int   mismatch_count;
    int   selections_due;
    int   found_count;
    int   empty_count;
    int   aborted_count;

    cfg_t aim;
    logic calm;
    int   gap_pct;
    int   counted = 0;
    int   items_sent = 0;
    int   writes_done = 0;

    display_mode_best_match_selector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dmbms_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .selections_due (selections_due),
        .found_count    (found_count),
        .empty_count    (empty_count),
        .aborted_count  (aborted_count)
    );

    always #1 aclk = ~aclk;

    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result-side backpressure in random bursts
    initial begin : sink_ready
        m_tready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic cfg_t make_prefs(input logic en, input logic [15:0] w,
                                        input logic [15:0] h, input logic [7:0] d,
                                        input logic [15:0] lb);
        cfg_t c;
        c.prefer_enable   = en;
        c.pref_width      = w;
        c.pref_height     = h;
        c.pref_depth      = d;
        c.pref_line_bytes = lb;
        return c;
    endfunction

    function automatic cfg_t pick_prefs();
        cfg_t c;
        case ($urandom_range(0, 5))
            0: c = '0;
            1: c = '1;
            2: c = make_prefs(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
            default: c = make_prefs(1'b0, WIDTHS[$urandom_range(0, 4)],
                                    HEIGHTS[$urandom_range(0, 4)],
                                    DEPTHS[$urandom_range(0, 2)],
                                    16'(WIDTHS[$urandom_range(0, 4)] * 4));
        endcase
        c.prefer_enable = ($urandom_range(0, 3) != 0);
        return c;
    endfunction

    function automatic mode_t make_mode(input logic [15:0] id, input logic [15:0] w,
                                        input logic [15:0] h, input logic [7:0] d,
                                        input logic [15:0] lb, input logic [31:0] base,
                                        input logic [7:0] model, input logic [15:0] attr);
        mode_t m;
        m.mode_number     = id;
        m.query_failed    = 1'b0;
        m.mode_width      = w;
        m.mode_height     = h;
        m.pixel_bits      = d;
        m.scan_line_bytes = lb;
        m.frame_base      = base;
        m.mem_layout      = model;
        m.attributes      = attr;
        return m;
    endfunction

    // values clustered around the preference so scores tie and differ by one
    function automatic logic [15:0] near16(input logic [15:0] target, input logic [15:0] typical);
        case ($urandom_range(0, 5))
            0, 1: return target;
            2: return target + 16'd1;
            3: return target - 16'd1;
            4: return typical;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic mode_t good_mode();
        mode_t m;
        m.mode_number     = 16'($urandom_range(0, 65534));
        m.query_failed    = 1'b0;
        m.mode_width      = near16(aim.pref_width, WIDTHS[$urandom_range(0, 4)]);
        m.mode_height     = near16(aim.pref_height, HEIGHTS[$urandom_range(0, 4)]);
        m.pixel_bits      = DEPTHS[$urandom_range(0, 2)];
        m.scan_line_bytes = near16(aim.pref_line_bytes, 16'(m.mode_width * 4));
        m.frame_base      = $urandom;
        if (m.frame_base == '0) m.frame_base = 32'd1;
        m.mem_layout      = $urandom_range(0, 1) ? MM_PACKED : MM_DIRECT;
        m.attributes      = 16'($urandom) | NEED_ATTR;
        return m;
    endfunction

    function automatic mode_t broken_mode();
        mode_t m;
        m = good_mode();
        case ($urandom_range(0, 4))
            0: begin
                m.mem_layout = 8'($urandom);
                if (m.mem_layout == MM_PACKED || m.mem_layout == MM_DIRECT)
                    m.mem_layout = MM_PLANAR;
            end
            1: m.frame_base = '0;
            2: m.attributes[NEED_BITS[$urandom_range(0, 4)]] = 1'b0;
            3: begin
                m.pixel_bits = 8'($urandom);
                if (m.pixel_bits == DEPTH_16 || m.pixel_bits == DEPTH_24 ||
                    m.pixel_bits == DEPTH_32)
                    m.pixel_bits = m.pixel_bits + 8'd1;
            end
            default: begin
                m.mode_width      = 16'($urandom);
                m.mode_height     = 16'($urandom);
                m.pixel_bits      = 8'($urandom);
                m.scan_line_bytes = 16'($urandom);
                m.frame_base      = $urandom;
                m.mem_layout      = 8'($urandom);
                m.attributes      = 16'($urandom);
            end
        endcase
        return m;
    endfunction

    function automatic mode_t end_mark();
        mode_t m;
        m              = broken_mode();
        m.mode_number  = END_MARK;
        m.query_failed = 1'($urandom_range(0, 1));
        return m;
    endfunction

    task automatic push_mode(input mode_t m);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {m.attributes, m.mem_layout, m.frame_base, m.scan_line_bytes,
                     m.pixel_bits, m.mode_height, m.mode_width, m.mode_number};
        s_tuser  <= m.query_failed;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // hold off until every selection is back and the pipeline has emptied
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (selections_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        writes_done++;
    endtask

    task automatic load_prefs(input cfg_t c);
        write_reg(REG_PREFER_ENABLE, {31'd0, c.prefer_enable});
        write_reg(REG_PREF_WIDTH, {16'd0, c.pref_width});
        write_reg(REG_PREF_HEIGHT, {16'd0, c.pref_height});
        write_reg(REG_PREF_DEPTH, {24'd0, c.pref_depth});
        write_reg(REG_PREF_LINE_BYTES, {16'd0, c.pref_line_bytes});
        aim = c;
    endtask

    task automatic send_list(input int len);
        int    retune_at;
        int    roll;
        mode_t m;
        retune_at = -1;
        if (len > 0 && $urandom_range(0, 3) == 0) retune_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            if (i == retune_at) begin
                settle();
                load_prefs(pick_prefs());
            end
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                m = good_mode();
            end else if (roll < 98) begin
                m = broken_mode();
            end else begin
                m = good_mode();
                m.query_failed = 1'b1;
            end
            counted++;
            push_mode(m);
        end
        push_mode(end_mark());
        counted++;
    endtask

    initial begin : stimulus
        mode_t t;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        calm     <= 1'b0;
        aim      = '0;
        gap_pct  = 25;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // largest-mode search: empty list, then every filter tripped once
        push_mode(end_mark());
        push_mode(make_mode(16'd0, 16'd640, 16'd480, DEPTH_16, 16'd1280, 32'h1, MM_PACKED,
                            NEED_ATTR));
        push_mode(make_mode(16'h0101, 16'd4096, 16'd4096, DEPTH_32, 16'd8192, 32'h1000,
                            MM_PLANAR, NEED_ATTR));
        push_mode(make_mode(16'h0102, 16'd4096, 16'd4096, DEPTH_32, 16'd8192, 32'h0, MM_DIRECT,
                            NEED_ATTR));
        push_mode(make_mode(16'h0103, 16'd4096, 16'd4096, DEPTH_32, 16'd8192, 32'h1000,
                            MM_DIRECT, NEED_ATTR & ~16'h0080));
        push_mode(make_mode(16'h0104, 16'd4096, 16'd4096, 8'd8, 16'd8192, 32'h1000, MM_DIRECT,
                            16'hFFFF));
        push_mode(make_mode(16'hFFFE, 16'hFFFF, 16'hFFFF, DEPTH_32, 16'hFFFF, 32'hFFFF_FFFF,
                            MM_DIRECT, 16'hFFFF));
        push_mode(make_mode(16'h0105, 16'd800, 16'd600, DEPTH_24, 16'd3200, 32'h2000, MM_PACKED,
                            NEED_ATTR));
        push_mode(end_mark());

        // failed query aborts the list, terminator flag ignored, state cleared after
        push_mode(make_mode(16'h0200, 16'd1024, 16'd768, DEPTH_32, 16'd4096, 32'h3000, MM_DIRECT,
                            NEED_ATTR));
        t = make_mode(16'h0201, 16'd1280, 16'd1024, DEPTH_32, 16'd5120, 32'h4000, MM_DIRECT,
                      NEED_ATTR);
        t.query_failed = 1'b1;
        push_mode(t);
        push_mode(make_mode(16'h0202, 16'd1920, 16'd1080, DEPTH_32, 16'd7680, 32'h5000,
                            MM_DIRECT, NEED_ATTR));
        t = end_mark();
        t.query_failed = 1'b1;
        push_mode(t);
        t.query_failed = 1'b0;
        push_mode(t);

        // closest match with an exact tie, earliest one kept
        settle();
        load_prefs(make_prefs(1'b1, 16'd1024, 16'd768, DEPTH_32, 16'd4096));
        push_mode(make_mode(16'h0300, 16'd1024, 16'd768, DEPTH_24, 16'd4096, 32'h6000, MM_PACKED,
                            NEED_ATTR));
        push_mode(make_mode(16'h0301, 16'd1024, 16'd768, DEPTH_32, 16'd4096, 32'h7000, MM_DIRECT,
                            NEED_ATTR));
        push_mode(make_mode(16'h0302, 16'd1024, 16'd768, DEPTH_32, 16'd4096, 32'h8000, MM_DIRECT,
                            NEED_ATTR));
        push_mode(end_mark());

        // worst score against an all-ones preference
        settle();
        load_prefs('1);
        push_mode(make_mode(16'h0400, 16'd0, 16'd0, DEPTH_16, 16'd0, 32'h9000, MM_PACKED,
                            NEED_ATTR));
        push_mode(end_mark());

        // preference switched off in the middle of a list
        settle();
        load_prefs(make_prefs(1'b1, 16'd0, 16'd0, 8'd0, 16'd0));
        push_mode(make_mode(16'h0500, 16'd640, 16'd480, DEPTH_16, 16'd1280, 32'hA000, MM_PACKED,
                            NEED_ATTR));
        settle();
        load_prefs('0);
        push_mode(make_mode(16'h0501, 16'd800, 16'd600, DEPTH_24, 16'd2400, 32'hB000, MM_DIRECT,
                            NEED_ATTR));
        push_mode(end_mark());

        while (counted < ITEM_GOAL) begin
            settle();
            if (counted > CALM_AFTER) calm <= 1'b1;
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            load_prefs(pick_prefs());
            repeat ($urandom_range(1, 5)) begin
                send_list(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 14));
            end
        end
        settle();

        $display("covered %0d mode lists: %0d picked a mode, %0d found none, %0d aborted",
                 found_count + empty_count + aborted_count, found_count, empty_count,
                 aborted_count);
        $display("%0d input transactions and %0d register writes across both search styles",
                 items_sent, writes_done);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
